### rtl/erts_pkg.sv
// ----------------------------------------------------------------------------
// erts_pkg
// Shared types and constants for the range-reduced Taylor exponential core.
// ----------------------------------------------------------------------------
package erts_pkg;

  localparam int unsigned WORK_BITS = 31;   // Q31 working fraction
  localparam int unsigned TW        = 32;   // series value width
  localparam int unsigned RW        = 30;   // |r| width, |r| <= ln2/2
  localparam int unsigned MW        = 36;   // reduced argument width, Q31
  localparam int unsigned KW        = 5;    // k width
  localparam int unsigned K_MAX     = 30;
  localparam int unsigned MAG_LIMIT = 21;

  localparam logic [WORK_BITS-1:0] LN2_Q31 = 31'd1488522236;

  typedef struct packed {
    logic          neg;
    logic          sat;
    logic [KW-1:0] k;
  } side_t;

  typedef struct packed {
    logic [TW-1:0] t;
    logic [RW-1:0] ra;
    logic          rneg;
    side_t         side;
  } work_t;

  typedef struct packed {
    logic [TW-1:0] rem;
    logic [30:0]   quo;
    logic [TW-1:0] t;
    logic [30:0]   pos;
    side_t         side;
  } recip_t;

  // Threshold (2j+1)*ln2, compared against 2*m
  function automatic logic [MW:0] k_thresh(int unsigned j);
    logic [63:0] p;
    p = 64'(2 * j + 1) * 64'(LN2_Q31);
    return p[MW:0];
  endfunction

endpackage

### rtl/erts_term.sv
// ----------------------------------------------------------------------------
// erts_term
// One Horner step: t = 1 +/- round(floor(t*|r| / DIV) / 2^31), four stages.
// ----------------------------------------------------------------------------
module erts_term import erts_pkg::*; #(
  parameter int unsigned DIV = 1
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  work_t in_work,
  output logic  out_valid,
  input  logic  out_ready,
  output work_t out_work
);

  localparam logic [34:0] RECIP = 35'((64'd1 << 34) / DIV);
  localparam logic [62:0] BIAS  = 63'(DIV) << 30;

  logic          v1_r, v2_r, v3_r, v4_r;
  logic          en1, en2, en3, en4;
  work_t         w1_r, w2_r, w3_r, w4_r;
  logic [61:0]   prod_r;
  logic [31:0]   h2_r, h3_r;
  logic [31:0]   est_r;

  logic [62:0]   sum;
  logic [66:0]   qprod;
  logic [31:0]   rem;
  logic [31:0]   q;
  logic [TW-1:0] t_nxt;
  work_t         w4_nxt;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // floor(floor(P/i) + 2^30) / 2^31) == floor(floor((P + i*2^30)/2^31) / i)
  assign sum   = {1'b0, prod_r} + BIAS;
  assign qprod = 67'(h2_r) * 67'(RECIP);
  // estimate is exact or one low
  assign rem   = h3_r - 32'(est_r * 32'(DIV));
  assign q     = (rem >= 32'(DIV)) ? est_r + 32'd1 : est_r;

  always_comb begin
    t_nxt = w3_r.rneg ? (TW'(1) << WORK_BITS) - q : (TW'(1) << WORK_BITS) + q;
    w4_nxt   = w3_r;
    w4_nxt.t = t_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      w1_r   <= in_work;
      prod_r <= 62'(in_work.t) * 62'(in_work.ra);
    end
    if (en2 && v1_r) begin
      w2_r <= w1_r;
      h2_r <= sum[62:31];
    end
    if (en3 && v2_r) begin
      w3_r  <= w2_r;
      h3_r  <= h2_r;
      est_r <= qprod[65:34];
    end
    if (en4 && v3_r) begin
      w4_r <= w4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_work  = w4_r;

endmodule

### rtl/exp_range_reduced_taylor_core.sv
// ----------------------------------------------------------------------------
// exp_range_reduced_taylor_core
// e^x for a signed Q15.16 argument: range reduction by ln2, Horner series,
// reciprocal for negative arguments. Result = mantissa * 2^exponent.
// ----------------------------------------------------------------------------
//  channel | dir | fields (low bit up)
//  in_     | in  | tdata: x_value[31:0]
//  out_    | out | tdata: mantissa[30:0], exponent[36:31], pad; tuser: saturated
//
//  One item per cycle unless out_tready stalls the pipeline; it has four stages
//  per series term and one quotient bit per divider stage after a setup stage.
//  Synchronous active-low reset clears all valid bits.
//  Each stage holds only when it is full and the next one is stalled, so
//  bubbles collapse and the input keeps flowing while a result waits.
// ----------------------------------------------------------------------------
module exp_range_reduced_taylor_core import erts_pkg::*; #(
  parameter int unsigned TERMS         = 14,
  parameter int unsigned IN_FRAC_BITS  = 16,
  parameter int unsigned OUT_FRAC_BITS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_value[31:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // mantissa[30:0], exponent[36:31], zero pad
  output logic        out_tuser   // saturated
);

  localparam int unsigned DS = OUT_FRAC_BITS + 1;
  localparam logic [31:0] LIM = 32'(MAG_LIMIT) << IN_FRAC_BITS;

  // ---- front end: abs/clamp, compare, k, k*ln2, remainder
  logic                a_v_r, b_v_r, c_v_r, d_v_r, e_v_r;
  logic                en_a, en_b, en_c, en_d, en_e;
  side_t               a_side_r, b_side_r, c_side_r, d_side_r;
  logic [MW-1:0]       a_m_r, b_m_r, c_m_r, d_m_r;
  logic [K_MAX-1:0]    b_cmp_r;
  logic [MW-1:0]       d_kl_r;
  work_t               e_work_r;

  logic [31:0]         mag, magc;
  logic                x_neg, x_sat;
  logic [K_MAX-1:0]    cmp;
  logic                r_neg;
  logic [MW-1:0]       r_abs;

  work_t               tw   [TERMS+1];
  logic                tv   [TERMS+1];
  logic                tr   [TERMS+1];

  recip_t              d_r   [DS+1];
  recip_t              d_nxt [DS+1];
  logic                dv_r  [DS+1];
  logic                den   [DS+2];

  logic                o_v_r;
  logic [30:0]         o_mant_r;
  logic [5:0]          o_exp_r;
  logic                o_sat_r;

  logic [32:0]         pos_sum;

  assign x_neg = in_tdata[31];
  assign mag   = x_neg ? (~in_tdata + 32'd1) : in_tdata;
  assign x_sat = mag > LIM;
  assign magc  = x_sat ? LIM : mag;

  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      cmp[j] = {a_m_r, 1'b0} > k_thresh(j);
    end
  end

  assign r_neg = d_m_r < d_kl_r;
  assign r_abs = r_neg ? d_kl_r - d_m_r : d_m_r - d_kl_r;

  assign en_e      = !e_v_r || tr[0];
  assign en_d      = !d_v_r || en_e;
  assign en_c      = !c_v_r || en_d;
  assign en_b      = !b_v_r || en_c;
  assign en_a      = !a_v_r || en_b;
  assign in_tready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      if (en_a) a_v_r <= in_tvalid;
      if (en_b) b_v_r <= a_v_r;
      if (en_c) c_v_r <= b_v_r;
      if (en_d) d_v_r <= c_v_r;
      if (en_e) e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_tvalid) begin
      a_m_r        <= MW'(magc) << (WORK_BITS - IN_FRAC_BITS);
      a_side_r.neg <= x_neg;
      a_side_r.sat <= x_sat;
      a_side_r.k   <= '0;
    end
    if (en_b && a_v_r) begin
      b_m_r    <= a_m_r;
      b_cmp_r  <= cmp;
      b_side_r <= a_side_r;
    end
    if (en_c && b_v_r) begin
      c_m_r        <= b_m_r;
      c_side_r.neg <= b_side_r.neg;
      c_side_r.sat <= b_side_r.sat;
      c_side_r.k   <= KW'($countones(b_cmp_r));
    end
    if (en_d && c_v_r) begin
      d_m_r    <= c_m_r;
      d_kl_r   <= MW'(c_side_r.k) * MW'(LN2_Q31);
      d_side_r <= c_side_r;
    end
    if (en_e && d_v_r) begin
      e_work_r.t    <= TW'(1) << WORK_BITS;
      e_work_r.ra   <= r_abs[RW-1:0];
      e_work_r.rneg <= r_neg;
      e_work_r.side <= d_side_r;
    end
  end

  // ---- series, Horner order: divisors TERMS down to 1
  assign tv[0] = e_v_r;
  assign tw[0] = e_work_r;

  for (genvar n = 0; n < TERMS; n++) begin : g_term
    erts_term #(
      .DIV (TERMS - n)
    ) u_term (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (tv[n]),
      .in_ready  (tr[n]),
      .in_work   (tw[n]),
      .out_valid (tv[n+1]),
      .out_ready (tr[n+1]),
      .out_work  (tw[n+1])
    );
  end

  // ---- reciprocal: restoring divide of 2^(OFB+31) + t/2 by t, one bit a stage
  assign pos_sum = 33'(tw[TERMS].t) + (33'd1 << (WORK_BITS - OUT_FRAC_BITS - 1));

  always_comb begin
    logic [TW:0] cur;
    int unsigned b;
    d_nxt[0].t    = tw[TERMS].t;
    d_nxt[0].side = tw[TERMS].side;
    d_nxt[0].quo  = '0;
    d_nxt[0].pos  = 31'(pos_sum >> (WORK_BITS - OUT_FRAC_BITS));
    d_nxt[0].rem  = (TW'(1) << 30) + (tw[TERMS].t >> (OUT_FRAC_BITS + 2));
    for (int j = 1; j <= DS; j++) begin
      b        = OUT_FRAC_BITS - (j - 1);
      cur      = {d_r[j-1].rem, d_r[j-1].t[b+1]};
      d_nxt[j] = d_r[j-1];
      if (cur >= {1'b0, d_r[j-1].t}) begin
        d_nxt[j].rem = TW'(cur - {1'b0, d_r[j-1].t});
        d_nxt[j].quo = {d_r[j-1].quo[29:0], 1'b1};
      end else begin
        d_nxt[j].rem = cur[TW-1:0];
        d_nxt[j].quo = {d_r[j-1].quo[29:0], 1'b0};
      end
    end
  end

  always_comb begin
    den[DS+1] = !o_v_r || out_tready;
    for (int j = DS; j >= 0; j--) begin
      den[j] = !dv_r[j] || den[j+1];
    end
  end

  assign tr[TERMS] = den[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= DS; j++) begin
        dv_r[j] <= 1'b0;
      end
      o_v_r <= 1'b0;
    end else begin
      if (den[0]) dv_r[0] <= tv[TERMS];
      for (int j = 1; j <= DS; j++) begin
        if (den[j]) dv_r[j] <= dv_r[j-1];
      end
      if (den[DS+1]) o_v_r <= dv_r[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (den[0] && tv[TERMS]) d_r[0] <= d_nxt[0];
    for (int j = 1; j <= DS; j++) begin
      if (den[j] && dv_r[j-1]) d_r[j] <= d_nxt[j];
    end
    if (den[DS+1] && dv_r[DS]) begin
      o_mant_r <= d_r[DS].side.neg ? d_r[DS].quo : d_r[DS].pos;
      o_exp_r  <= d_r[DS].side.neg ? 6'd0 - 6'(d_r[DS].side.k) : 6'(d_r[DS].side.k);
      o_sat_r  <= d_r[DS].side.sat;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {3'b000, o_exp_r, o_mant_r};
  assign out_tuser  = o_sat_r;

endmodule
